// ===== sv/tcphc_pkg.sv =====
// shared types and constants for the tcp/http frame classifier
`timescale 1ns / 1ps
package tcphc_pkg;

    localparam int unsigned ETH_HDR_BYTES = 14;
    localparam int unsigned MIN_HDR_BYTES = 20;
    localparam int unsigned PREFIX_COUNT  = 8;
    localparam int unsigned PREFIX_SPAN   = 8;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

    localparam logic [15:0] HTTP_PORT_FIRST_RST  = 16'd80;
    localparam logic [15:0] HTTP_PORT_SECOND_RST = 16'd8080;
    localparam logic [15:0] HTTP_PORT_THIRD_RST  = 16'd8000;

    localparam logic [1:0] CFG_HTTP_PORT_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HTTP_PORT_SECOND = 2'd1;
    localparam logic [1:0] CFG_HTTP_PORT_THIRD  = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_DROP  = 2'd0,
        VERDICT_EMPTY = 2'd1,
        VERDICT_HTTP  = 2'd2,
        VERDICT_OTHER = 2'd3
    } verdict_t;

    // method and status-line prefixes, zero padded
    localparam logic [7:0] PREFIX_TEXT [PREFIX_COUNT][PREFIX_SPAN] = '{
        '{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", " ", 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", " ", 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", " ", 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S", " "},
        '{"P", "A", "T", "C", "H", " ", 8'h00, 8'h00},
        '{"H", "T", "T", "P", "/", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] PREFIX_CHARS [PREFIX_COUNT] = '{
        4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd6, 4'd5
    };

    typedef struct packed {
        logic [15:0] cap;
        logic [15:0] ethertype;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [15:0] fragment_word;
        logic [7:0]  protocol;
        logic [31:0] ports;
        logic [3:0]  data_offset;
        logic [7:0]  prefix_flags;
    } frame_snap_t;

endpackage

// ===== sv/tcp_http_frame_classifier_top.sv =====
// Frame bytes stream in one per beat, s_tlast on the final byte; one verdict beat
// per frame comes out on the m_ side. The block takes one byte every cycle unless
// back-pressure holds a frame's last byte; each byte updates the captured header
// fields and the prefix match flags. The last byte passes the input, frame snapshot
// and result registers before the verdict. Frames that are not unfragmented IPv4/TCP
// with sane lengths, or are captured too short, give verdict 0 with every field zero.
// Bytes from position MAX_CAPTURE_BYTES on are ignored. The user must set the three
// HTTP ports via cfg (index 0..2) only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module tcp_http_frame_classifier_top #(
    parameter int unsigned MAX_CAPTURE_BYTES = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // verdict[1:0], source_port[17:2], destination_port[33:18], ip_header_bytes[39:34],
    // tcp_header_bytes[45:40], payload_bytes[61:46], captured_payload_bytes[77:62]
    output logic [79:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tcphc_pkg::*;

    localparam logic [16:0] ETH17     = 17'(ETH_HDR_BYTES);
    localparam logic [16:0] MAXCAP17  = 17'(MAX_CAPTURE_BYTES);
    localparam logic [16:0] MINHDR17  = 17'(MIN_HDR_BYTES);

    // configuration
    logic [15:0] port_first_reg, port_second_reg, port_third_reg;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // per-frame state
    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] ethertype_reg, ethertype_next;
    logic [7:0]  version_ihl_reg, version_ihl_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [15:0] fragment_word_reg, fragment_word_next;
    logic [7:0]  protocol_reg, protocol_next;
    logic [31:0] ports_reg, ports_next;
    logic [3:0]  data_offset_reg, data_offset_next;
    logic [7:0]  prefix_flags_reg, prefix_flags_next;

    // frame snapshot
    logic        snap_valid_reg, snap_valid_next;
    frame_snap_t snap_reg, snap_now;

    // result register
    logic        m_valid_reg, m_valid_next;
    verdict_t    verdict_reg, verdict_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [5:0]  ihl4_reg, ihl4_next;
    logic [5:0]  thl_reg, thl_next;
    logic [15:0] pay_reg, pay_next;
    logic [15:0] cpay_reg, cpay_next;

    // handshake
    logic out_ready, snap_ready, s1_adv, s_accept;

    assign out_ready  = !m_valid_reg || m_tready;
    assign snap_ready = !snap_valid_reg || out_ready;
    assign s1_adv     = s1_valid_reg && (!s1_last_reg || snap_ready);
    assign s_tready   = !s1_valid_reg || s1_adv;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    // per-byte header capture
    logic [15:0] ethertype_upd, total_length_upd, fragment_word_upd;
    logic [7:0]  version_ihl_upd, protocol_upd, prefix_flags_upd;
    logic [31:0] ports_upd;
    logic [3:0]  data_offset_upd;
    logic [16:0] pos17, tcp_start, rel, pay_start, off;
    logic        in_range;

    always_comb begin
        pos17    = {1'b0, byte_position_reg};
        in_range = pos17 < MAXCAP17;

        ethertype_upd = ethertype_reg;
        if (pos17 == 17'd12) ethertype_upd[15:8] = s1_byte_reg;
        if (pos17 == 17'd13) ethertype_upd[7:0] = s1_byte_reg;
        version_ihl_upd = (pos17 == ETH17) ? s1_byte_reg : version_ihl_reg;
        total_length_upd = total_length_reg;
        if (pos17 == ETH17 + 17'd2) total_length_upd[15:8] = s1_byte_reg;
        if (pos17 == ETH17 + 17'd3) total_length_upd[7:0] = s1_byte_reg;
        fragment_word_upd = fragment_word_reg;
        if (pos17 == ETH17 + 17'd6) fragment_word_upd[15:8] = s1_byte_reg;
        if (pos17 == ETH17 + 17'd7) fragment_word_upd[7:0] = s1_byte_reg;
        protocol_upd = (pos17 == ETH17 + 17'd9) ? s1_byte_reg : protocol_reg;

        tcp_start = ETH17 + {11'd0, version_ihl_upd[3:0], 2'b00};
        rel       = pos17 - tcp_start;
        ports_upd = ports_reg;
        if (pos17 >= tcp_start && rel < 17'd4) begin
            unique case (rel[1:0])
                2'd0: ports_upd[31:24] = s1_byte_reg;
                2'd1: ports_upd[23:16] = s1_byte_reg;
                2'd2: ports_upd[15:8]  = s1_byte_reg;
                default: ports_upd[7:0] = s1_byte_reg;
            endcase
        end
        data_offset_upd = (pos17 == tcp_start + 17'd12) ? s1_byte_reg[7:4] : data_offset_reg;

        pay_start        = tcp_start + {11'd0, data_offset_upd, 2'b00};
        off              = pos17 - pay_start;
        prefix_flags_upd = prefix_flags_reg;
        if (data_offset_upd >= MIN_HDR_WORDS && pos17 > tcp_start + 17'd12
                && pos17 >= pay_start && off < 17'(PREFIX_SPAN)) begin
            for (int p = 0; p < PREFIX_COUNT; p++) begin
                if ({1'b0, off[2:0]} < PREFIX_CHARS[p]
                        && s1_byte_reg != PREFIX_TEXT[p][off[2:0]]) begin
                    prefix_flags_upd[p] = 1'b0;
                end
            end
        end

        if (!in_range) begin
            ethertype_upd     = ethertype_reg;
            version_ihl_upd   = version_ihl_reg;
            total_length_upd  = total_length_reg;
            fragment_word_upd = fragment_word_reg;
            protocol_upd      = protocol_reg;
            ports_upd         = ports_reg;
            data_offset_upd   = data_offset_reg;
            prefix_flags_upd  = prefix_flags_reg;
        end

        snap_now = '{
            cap:           in_range ? byte_position_reg + 16'd1 : byte_position_reg,
            ethertype:     ethertype_upd,
            version_ihl:   version_ihl_upd,
            total_length:  total_length_upd,
            fragment_word: fragment_word_upd,
            protocol:      protocol_upd,
            ports:         ports_upd,
            data_offset:   data_offset_upd,
            prefix_flags:  prefix_flags_upd
        };

        byte_position_next = byte_position_reg;
        ethertype_next     = ethertype_reg;
        version_ihl_next   = version_ihl_reg;
        total_length_next  = total_length_reg;
        fragment_word_next = fragment_word_reg;
        protocol_next      = protocol_reg;
        ports_next         = ports_reg;
        data_offset_next   = data_offset_reg;
        prefix_flags_next  = prefix_flags_reg;
        if (s1_adv) begin
            if (s1_last_reg) begin
                byte_position_next = '0;
                ethertype_next     = '0;
                version_ihl_next   = '0;
                total_length_next  = '0;
                fragment_word_next = '0;
                protocol_next      = '0;
                ports_next         = '0;
                data_offset_next   = '0;
                prefix_flags_next  = '1;
            end else begin
                byte_position_next = snap_now.cap;
                ethertype_next     = ethertype_upd;
                version_ihl_next   = version_ihl_upd;
                total_length_next  = total_length_upd;
                fragment_word_next = fragment_word_upd;
                protocol_next      = protocol_upd;
                ports_next         = ports_upd;
                data_offset_next   = data_offset_upd;
                prefix_flags_next  = prefix_flags_upd;
            end
        end
    end

    // verdict
    logic [5:0]  ihl4, thl;
    logic [16:0] cap17, total17, ip_end, hdr_sum, all_end, pay17, cpay17, cpay_cl;
    logic        drop, port_hit, prefix_hit;

    always_comb begin
        ihl4    = {snap_reg.version_ihl[3:0], 2'b00};
        thl     = {snap_reg.data_offset, 2'b00};
        cap17   = {1'b0, snap_reg.cap};
        total17 = {1'b0, snap_reg.total_length};
        ip_end  = ETH17 + {11'd0, ihl4};
        hdr_sum = {11'd0, ihl4} + {11'd0, thl};
        all_end = ip_end + {11'd0, thl};

        drop = cap17 < ETH17
            || snap_reg.ethertype != ETHERTYPE_IPV4
            || cap17 < ETH17 + MINHDR17
            || snap_reg.version_ihl[7:4] != IP_VERSION_4
            || {11'd0, ihl4} < MINHDR17
            || cap17 < ip_end
            || snap_reg.protocol != PROTO_TCP
            || snap_reg.fragment_word[13:0] != 14'd0
            || total17 < {11'd0, ihl4}
            || cap17 < ip_end + MINHDR17
            || {11'd0, thl} < MINHDR17
            || total17 < hdr_sum
            || cap17 < all_end;

        pay17   = total17 - hdr_sum;
        cpay17  = cap17 - all_end;
        cpay_cl = (cpay17 > pay17) ? pay17 : cpay17;

        port_hit = snap_reg.ports[31:16] == port_first_reg
            || snap_reg.ports[15:0] == port_first_reg
            || snap_reg.ports[31:16] == port_second_reg
            || snap_reg.ports[15:0] == port_second_reg
            || snap_reg.ports[31:16] == port_third_reg
            || snap_reg.ports[15:0] == port_third_reg;
        prefix_hit = 1'b0;
        for (int p = 0; p < PREFIX_COUNT; p++) begin
            if (snap_reg.prefix_flags[p] && cpay_cl >= {13'd0, PREFIX_CHARS[p]}) begin
                prefix_hit = 1'b1;
            end
        end

        verdict_next = VERDICT_OTHER;
        sport_next   = snap_reg.ports[31:16];
        dport_next   = snap_reg.ports[15:0];
        ihl4_next    = ihl4;
        thl_next     = thl;
        pay_next     = pay17[15:0];
        cpay_next    = cpay_cl[15:0];
        priority if (drop) begin
            verdict_next = VERDICT_DROP;
            sport_next   = '0;
            dport_next   = '0;
            ihl4_next    = '0;
            thl_next     = '0;
            pay_next     = '0;
            cpay_next    = '0;
        end else if (pay17 == 17'd0) begin
            verdict_next = VERDICT_EMPTY;
        end else if (cpay_cl != 17'd0 && (port_hit || prefix_hit)) begin
            verdict_next = VERDICT_HTTP;
        end else begin
            verdict_next = VERDICT_OTHER;
        end
    end

    always_comb begin
        s1_valid_next   = s_tready ? s_tvalid : s1_valid_reg;
        snap_valid_next = snap_ready ? (s1_adv && s1_last_reg) : snap_valid_reg;
        m_valid_next    = out_ready ? snap_valid_reg : m_valid_reg;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg      <= 1'b0;
            snap_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
            byte_position_reg <= '0;
            ethertype_reg     <= '0;
            version_ihl_reg   <= '0;
            total_length_reg  <= '0;
            fragment_word_reg <= '0;
            protocol_reg      <= '0;
            ports_reg         <= '0;
            data_offset_reg   <= '0;
            prefix_flags_reg  <= '1;
            port_first_reg    <= HTTP_PORT_FIRST_RST;
            port_second_reg   <= HTTP_PORT_SECOND_RST;
            port_third_reg    <= HTTP_PORT_THIRD_RST;
        end else begin
            s1_valid_reg      <= s1_valid_next;
            snap_valid_reg    <= snap_valid_next;
            m_valid_reg       <= m_valid_next;
            byte_position_reg <= byte_position_next;
            ethertype_reg     <= ethertype_next;
            version_ihl_reg   <= version_ihl_next;
            total_length_reg  <= total_length_next;
            fragment_word_reg <= fragment_word_next;
            protocol_reg      <= protocol_next;
            ports_reg         <= ports_next;
            data_offset_reg   <= data_offset_next;
            prefix_flags_reg  <= prefix_flags_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_HTTP_PORT_FIRST:  port_first_reg  <= cfg_data;
                    CFG_HTTP_PORT_SECOND: port_second_reg <= cfg_data;
                    CFG_HTTP_PORT_THIRD:  port_third_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (snap_ready && s1_adv && s1_last_reg) begin
            snap_reg <= snap_now;
        end
        if (out_ready && snap_valid_reg) begin
            verdict_reg <= verdict_next;
            sport_reg   <= sport_next;
            dport_reg   <= dport_next;
            ihl4_reg    <= ihl4_next;
            thl_reg     <= thl_next;
            pay_reg     <= pay_next;
            cpay_reg    <= cpay_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, cpay_reg, pay_reg, thl_reg, ihl4_reg, dport_reg, sport_reg,
                       verdict_reg};

`ifndef SYNTHESIS
    a_result_from_snapshot: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(snap_valid_reg))
        else $error("result beat without a frame snapshot");

    a_drop_all_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && verdict_reg == VERDICT_DROP) |->
            (sport_reg == 16'd0 && dport_reg == 16'd0 && ihl4_reg == 6'd0
             && thl_reg == 6'd0 && pay_reg == 16'd0 && cpay_reg == 16'd0))
        else $error("dropped frame with nonzero fields");

    a_empty_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && verdict_reg == VERDICT_EMPTY) |-> (pay_reg == 16'd0 && cpay_reg == 16'd0))
        else $error("no-payload verdict with payload length");

    a_capture_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (cpay_reg <= pay_reg))
        else $error("captured payload exceeds payload length");

    a_frame_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_last_reg) |=> (byte_position_reg == 16'd0 && prefix_flags_reg == 8'hFF))
        else $error("frame state not cleared after last byte");
`endif

endmodule
